// ===== hdl/jes_pkg.sv =====
// Shared types, register indexes and message text for the joystick event serializer.
package jes_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CFG_HIGH_THRESHOLD = 4'd0;
  localparam logic [3:0] CFG_LOW_THRESHOLD  = 4'd1;
  localparam logic [3:0] CFG_REARM_MARGIN   = 4'd2;
  localparam logic [3:0] CFG_DEBOUNCE_TICKS = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [9:0] HIGH_THRESHOLD_RST = 10'd1000;
  localparam logic [9:0] LOW_THRESHOLD_RST  = 10'd24;
  localparam logic [7:0] REARM_MARGIN_RST   = 8'd10;
  localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd16;

  // Direction message codes.
  localparam logic [1:0] MSG_UP    = 2'd0;
  localparam logic [1:0] MSG_DOWN  = 2'd1;
  localparam logic [1:0] MSG_LEFT  = 2'd2;
  localparam logic [1:0] MSG_RIGHT = 2'd3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [3:0] SEL_LAST = 4'd7;

  // Outcome of one axis check.
  typedef struct packed {
    logic       advance;
    logic       fire;
    logic [1:0] msg;
    logic [3:0] latched;
  } axis_res_t;

  // One output item.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // Length of each direction message, CR LF included.
  function automatic logic [3:0] dir_len(input logic [1:0] msel);
    logic [3:0] len;
    case (msel)
      MSG_UP:   len = 4'd4;
      MSG_DOWN: len = 4'd6;
      MSG_LEFT: len = 4'd6;
      default:  len = 4'd7;
    endcase
    return len;
  endfunction

  // Character of a direction message at a position.
  function automatic logic [7:0] dir_char(input logic [1:0] msel, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_SPACE;
    case (msel)
      MSG_UP: begin
        case (pos)
          3'd0: ch = "U";
          3'd1: ch = "P";
          3'd2: ch = CH_CR;
          3'd3: ch = CH_LF;
          default: ch = CH_SPACE;
        endcase
      end
      MSG_DOWN: begin
        case (pos)
          3'd0: ch = "D";
          3'd1: ch = "O";
          3'd2: ch = "W";
          3'd3: ch = "N";
          3'd4: ch = CH_CR;
          3'd5: ch = CH_LF;
          default: ch = CH_SPACE;
        endcase
      end
      MSG_LEFT: begin
        case (pos)
          3'd0: ch = "L";
          3'd1: ch = "E";
          3'd2: ch = "F";
          3'd3: ch = "T";
          3'd4: ch = CH_CR;
          3'd5: ch = CH_LF;
          default: ch = CH_SPACE;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "R";
          3'd1: ch = "I";
          3'd2: ch = "G";
          3'd3: ch = "H";
          3'd4: ch = "T";
          3'd5: ch = CH_CR;
          3'd6: ch = CH_LF;
          default: ch = CH_SPACE;
        endcase
      end
    endcase
    return ch;
  endfunction

  // Character of the select message at a position.
  function automatic logic [7:0] sel_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = "S";
      3'd1: ch = "E";
      3'd2: ch = "L";
      3'd3: ch = "E";
      3'd4: ch = "C";
      3'd5: ch = "T";
      3'd6: ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/joystick_event_serializer_top.sv =====
// Joystick event serializer: poll state machine, message sequencing and output buffer.
// A result byte is registered into the output buffer when the poll item that causes it is accepted.
// Throughput: one poll item per cycle while in_ready is high; the state update is a single pass of compare logic.
// A two-entry output buffer keeps in_ready high while one result waits to be taken.
// Reset (synchronous, rst_n low): phase returns to the vertical check, flags, counters
// and buffer clear, and the configuration registers take their default values.
module joystick_event_serializer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_button_level,
  input  logic [9:0] in_y_sample,
  input  logic [9:0] in_x_sample,
  input  logic       in_tx_ready,
  input  logic       in_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_message
);

  // Phase codes.
  localparam logic [2:0] PH_VCHECK      = 3'd0;
  localparam logic [2:0] PH_HCHECK      = 3'd1;
  localparam logic [2:0] PH_SEND_START  = 3'd2;
  localparam logic [2:0] PH_DIR_SEND    = 3'd3;
  localparam logic [2:0] PH_PRESS_DEB   = 3'd4;
  localparam logic [2:0] PH_SEL_SEND    = 3'd5;
  localparam logic [2:0] PH_WAIT_REL    = 3'd6;
  localparam logic [2:0] PH_REL_DEB     = 3'd7;

  localparam logic [7:0] DCNT_MAX = 8'd255;

  // Configuration registers.
  logic [9:0] high_thr_r, low_thr_r;
  logic [7:0] margin_r, deb_ticks_r;

  // Poll state.
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] latched_r, latched_nxt;
  logic       pend_r, pend_nxt;
  logic [1:0] msel_r, msel_nxt;
  logic [3:0] cpos_r, cpos_nxt;
  logic [7:0] dcnt_r, dcnt_nxt;

  // Output buffer: main register and skid entry.
  jes_pkg::out_item_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;
  logic res_valid, restart, accept, pop, push, settled, pressed;
  jes_pkg::axis_res_t axis_y, axis_x;

  // Checks one axis sample against the thresholds and the re-arm band.
  function automatic jes_pkg::axis_res_t check_axis(
    input logic [9:0] v, input logic [3:0] latched, input logic [1:0] msel,
    input logic [1:0] down_bit, input logic [1:0] up_bit,
    input logic [1:0] down_msg, input logic [1:0] up_msg,
    input logic [9:0] lo_thr, input logic [9:0] hi_thr, input logic [7:0] margin);
    jes_pkg::axis_res_t r;
    logic [10:0] lo_band;
    logic [11:0] v_plus;
    r.advance = 1'b0;
    r.fire    = 1'b0;
    r.msg     = msel;
    r.latched = latched;
    lo_band   = {1'b0, lo_thr} + {3'b000, margin};
    v_plus    = {2'b00, v} + {4'h0, margin};
    if (v < lo_thr) begin
      r.advance = 1'b1;
      if (!latched[down_bit]) begin
        r.fire = 1'b1;
        r.msg  = down_msg;
        r.latched[down_bit] = 1'b1;
      end
    end else if (v > hi_thr) begin
      r.advance = 1'b1;
      if (!latched[up_bit]) begin
        r.fire = 1'b1;
        r.msg  = up_msg;
        r.latched[up_bit] = 1'b1;
      end
    end else if (({1'b0, v} >= lo_band) && (v_plus <= {2'b00, hi_thr})) begin
      r.advance = 1'b1;
      r.latched[down_bit] = 1'b0;
      r.latched[up_bit]   = 1'b0;
    end
    return r;
  endfunction

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign push     = accept && res_valid;
  assign pressed  = !in_button_level;
  assign settled  = dcnt_r >= deb_ticks_r;

  assign axis_y = check_axis(in_y_sample, latched_r, msel_r, 2'd0, 2'd1,
                             jes_pkg::MSG_DOWN, jes_pkg::MSG_UP,
                             low_thr_r, high_thr_r, margin_r);
  assign axis_x = check_axis(in_x_sample, latched_r, msel_r, 2'd2, 2'd3,
                             jes_pkg::MSG_RIGHT, jes_pkg::MSG_LEFT,
                             low_thr_r, high_thr_r, margin_r);

  // Next state and result for one poll item.
  always_comb begin
    phase_nxt   = phase_r;
    latched_nxt = latched_r;
    pend_nxt    = pend_r;
    msel_nxt    = msel_r;
    cpos_nxt    = cpos_r;
    restart     = 1'b0;
    res_valid   = 1'b0;
    res.tx_byte = jes_pkg::dir_char(msel_r, cpos_r[2:0]);
    res.last    = (cpos_r + 4'd1) == jes_pkg::dir_len(msel_r);
    unique case (phase_r)
      PH_VCHECK: begin
        if (pressed) begin
          restart   = 1'b1;
          phase_nxt = PH_PRESS_DEB;
        end else begin
          latched_nxt = axis_y.latched;
          msel_nxt    = axis_y.msg;
          if (axis_y.fire) pend_nxt = 1'b1;
          if (axis_y.advance) phase_nxt = PH_HCHECK;
        end
      end
      PH_HCHECK: begin
        latched_nxt = axis_x.latched;
        msel_nxt    = axis_x.msg;
        if (axis_x.fire) pend_nxt = 1'b1;
        if (axis_x.advance) phase_nxt = PH_SEND_START;
      end
      PH_SEND_START: begin
        if (!pend_r) begin
          phase_nxt = PH_VCHECK;
        end else begin
          pend_nxt    = 1'b0;
          res_valid   = 1'b1;
          res.tx_byte = jes_pkg::dir_char(msel_r, 3'd0);
          res.last    = jes_pkg::dir_len(msel_r) == 4'd1;
          cpos_nxt    = 4'd1;
          phase_nxt   = PH_DIR_SEND;
        end
      end
      PH_DIR_SEND: begin
        if (in_tx_ready) begin
          if (cpos_r >= jes_pkg::dir_len(msel_r)) begin
            phase_nxt = PH_VCHECK;
          end else begin
            res_valid = 1'b1;
            cpos_nxt  = cpos_r + 4'd1;
          end
        end
      end
      PH_PRESS_DEB: begin
        if (settled) begin
          if (pressed) begin
            res_valid   = 1'b1;
            res.tx_byte = jes_pkg::sel_char(3'd0);
            res.last    = 1'b0;
            cpos_nxt    = 4'd1;
            phase_nxt   = PH_SEL_SEND;
          end else begin
            phase_nxt = PH_VCHECK;
          end
        end
      end
      PH_SEL_SEND: begin
        if (in_tx_ready) begin
          if (!cpos_r[3]) begin
            res_valid   = 1'b1;
            res.tx_byte = jes_pkg::sel_char(cpos_r[2:0]);
            res.last    = cpos_r == jes_pkg::SEL_LAST;
            cpos_nxt    = cpos_r + 4'd1;
          end else begin
            phase_nxt = PH_WAIT_REL;
          end
        end
      end
      PH_WAIT_REL: begin
        if (!pressed) begin
          restart   = 1'b1;
          phase_nxt = PH_REL_DEB;
        end
      end
      PH_REL_DEB: begin
        if (settled) phase_nxt = pressed ? PH_WAIT_REL : PH_VCHECK;
      end
      default: phase_nxt = PH_VCHECK;
    endcase
    // Debounce counter uses the old count above; restart drops this tick.
    if (restart) dcnt_nxt = '0;
    else if (in_tick && (dcnt_r != DCNT_MAX)) dcnt_nxt = dcnt_r + 8'd1;
    else dcnt_nxt = dcnt_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= jes_pkg::HIGH_THRESHOLD_RST;
      low_thr_r   <= jes_pkg::LOW_THRESHOLD_RST;
      margin_r    <= jes_pkg::REARM_MARGIN_RST;
      deb_ticks_r <= jes_pkg::DEBOUNCE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jes_pkg::CFG_HIGH_THRESHOLD: high_thr_r  <= cfg_wdata;
        jes_pkg::CFG_LOW_THRESHOLD:  low_thr_r   <= cfg_wdata;
        jes_pkg::CFG_REARM_MARGIN:   margin_r    <= cfg_wdata[7:0];
        jes_pkg::CFG_DEBOUNCE_TICKS: deb_ticks_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Poll state update on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_VCHECK;
      latched_r <= '0;
      pend_r    <= 1'b0;
      msel_r    <= jes_pkg::MSG_UP;
      cpos_r    <= '0;
      dcnt_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      latched_r <= latched_nxt;
      pend_r    <= pend_nxt;
      msel_r    <= msel_nxt;
      cpos_r    <= cpos_nxt;
      dcnt_r    <= dcnt_nxt;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) skid_valid_r <= 1'b0;
    end else if (push) begin
      if (out_valid_r && !pop) skid_valid_r <= 1'b1;
      else out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (out_valid_r && !pop) skid_r <= res;
      else out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_byte         = out_r.tx_byte;
  assign out_last_of_message = out_r.last;

  // The skid entry is only ever filled behind a full main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid entry valid with empty output register");

  // Starting a pending direction message always enters the send phase.
  a_send_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_SEND_START) && pend_r) |=> (phase_r == PH_DIR_SEND))
    else $error("pending message did not start sending");

  // The character position never runs past the select message.
  a_cpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cpos_r <= 4'd8) else $error("character position out of range");

  // A result pushed while the buffer is full would be lost.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !pop) |=> (skid_valid_r && out_valid_r))
    else $error("result not held in output buffer");

endmodule
